/* hw/rtl/rpc_pkg.sv */
`timescale 1ns / 1ps

package rpc_pkg;

	// CORDIC: 30 micro-rotations in Q2.30
	localparam int CORDIC_STAGES = 30;
	localparam int CR_W          = 33;  // x, y, z datapath width inside the CORDIC
	localparam int CS_W          = 32;  // cosine / sine width, Q2.30
	localparam int PHASE_W       = 32;  // binary phase, 2^32 per turn

	// gain-compensated unit vector, Q2.30
	localparam logic signed [CR_W-1:0] CORDIC_GAIN = 33'sd652032874;

	// arctangent of 2^-i in phase units
	localparam logic signed [CR_W-1:0] ATAN_TAB [CORDIC_STAGES] = '{
		33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
		33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
		33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
		33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861,
		33'sd10430,     33'sd5215,      33'sd2608,      33'sd1304,
		33'sd652,       33'sd326,       33'sd163,       33'sd81,
		33'sd41,        33'sd20,        33'sd10,        33'sd5,
		33'sd3,         33'sd1
	};

	// rotation multiply: offsets are widened to EXT_W and split into
	// a signed high part and an unsigned low part of SPLIT bits
	localparam int EXT_W   = 49;             // widest offset (48-bit coords + 1)
	localparam int SPLIT   = 24;
	localparam int HI_W    = EXT_W - SPLIT;  // 25
	localparam int PROD_W  = HI_W + CS_W;    // 57
	localparam int PSUM_W  = PROD_W + 1;     // 58
	localparam int ACC_W   = PSUM_W + SPLIT + 1;
	localparam int FRAC    = 30;
	localparam int ROT_W   = ACC_W - FRAC;   // rotated offset width
	localparam int SUM_W   = ROT_W + 1;      // offset plus center

	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'sd1 <<< (FRAC - 1));

endpackage

/* hw/rtl/rpc_cordic.sv */
`timescale 1ns / 1ps

// Fully unrolled rotation-mode CORDIC, one micro-rotation per stage.
// Side data travels alongside each item untouched.
module rpc_cordic #(
	parameter int SIDE_W = 130
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [rpc_pkg::PHASE_W-1:0] in_z,
	input  logic [SIDE_W-1:0]                 in_side,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [rpc_pkg::CS_W-1:0]   out_cos,
	output logic signed [rpc_pkg::CS_W-1:0]   out_sin,
	output logic [SIDE_W-1:0]                 out_side
);

	localparam int N = rpc_pkg::CORDIC_STAGES;
	localparam int W = rpc_pkg::CR_W;

	// stage registers, index = micro-rotation number
	logic signed [W-1:0] x_s [N];
	logic signed [W-1:0] y_s [N];
	logic signed [W-1:0] z_s [N];
	logic [SIDE_W-1:0]   side_s [N];
	logic [N-1:0]        v_s;
	logic [N:0]          en;

	assign en[N] = out_ready;

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic signed [W-1:0] xp, yp, zp;
		logic signed [W-1:0] xn, yn, zn;
		logic                vp;
		logic [SIDE_W-1:0]   sp;

		if (i == 0) begin : g_first
			assign xp = rpc_pkg::CORDIC_GAIN;
			assign yp = '0;
			assign zp = W'(in_z);
			assign vp = in_valid;
			assign sp = in_side;
		end else begin : g_next
			assign xp = x_s[i-1];
			assign yp = y_s[i-1];
			assign zp = z_s[i-1];
			assign vp = v_s[i-1];
			assign sp = side_s[i-1];
		end

		// stage may load when empty or when its contents move on
		assign en[i] = ~v_s[i] | en[i+1];

		// micro-rotation toward zero residual phase
		always_comb begin
			if (!zp[W-1]) begin
				xn = xp - (yp >>> i);
				yn = yp + (xp >>> i);
				zn = zp - rpc_pkg::ATAN_TAB[i];
			end else begin
				xn = xp + (yp >>> i);
				yn = yp - (xp >>> i);
				zn = zp + rpc_pkg::ATAN_TAB[i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en[i]) begin
				v_s[i] <= vp;
			end
		end

		always_ff @(posedge clk) begin
			if (en[i]) begin
				x_s[i]    <= xn;
				y_s[i]    <= yn;
				z_s[i]    <= zn;
				side_s[i] <= sp;
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_s[N-1];
	assign out_cos   = x_s[N-1][rpc_pkg::CS_W-1:0];
	assign out_sin   = y_s[N-1][rpc_pkg::CS_W-1:0];
	assign out_side  = side_s[N-1];

endmodule

/* hw/rtl/rpc_rotate.sv */
`timescale 1ns / 1ps

// Rotates an offset by (cos, sin), rounds back to Q16.16, adds the center
// and saturates. Four stages: products, partial sums, round, center + clamp.
module rpc_rotate #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [rpc_pkg::CS_W-1:0]    cos_in,
	input  logic signed [rpc_pkg::CS_W-1:0]    sin_in,
	input  logic signed [COORD_WIDTH:0]        dx,
	input  logic signed [COORD_WIDTH:0]        dy,
	input  logic signed [COORD_WIDTH-1:0]      cx,
	input  logic signed [COORD_WIDTH-1:0]      cy,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [COORD_WIDTH-1:0]      out_x,
	output logic signed [COORD_WIDTH-1:0]      out_y
);

	localparam int EXT_W  = rpc_pkg::EXT_W;
	localparam int SPLIT  = rpc_pkg::SPLIT;
	localparam int HI_W   = rpc_pkg::HI_W;
	localparam int PROD_W = rpc_pkg::PROD_W;
	localparam int PSUM_W = rpc_pkg::PSUM_W;
	localparam int ACC_W  = rpc_pkg::ACC_W;
	localparam int ROT_W  = rpc_pkg::ROT_W;
	localparam int SUM_W  = rpc_pkg::SUM_W;
	localparam int FRAC   = rpc_pkg::FRAC;

	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

	// stall chain
	logic [3:0] v_q;
	logic [3:0] v_in;
	logic [4:0] en;
	assign en[4] = out_ready;
	assign v_in  = {v_q[2:0], in_valid};
	for (genvar k = 0; k < 4; k++) begin : g_en
		assign en[k] = ~v_q[k] | en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int k = 0; k < 4; k++) begin
				if (en[k]) begin
					v_q[k] <= v_in[k];
				end
			end
		end
	end

	// split offsets: signed high part, unsigned low part
	logic signed [EXT_W-1:0] dx_ext, dy_ext;
	logic signed [HI_W-1:0]  hdx, ldx, hdy, ldy;
	assign dx_ext = EXT_W'(dx);
	assign dy_ext = EXT_W'(dy);
	assign hdx    = dx_ext[EXT_W-1:SPLIT];
	assign hdy    = dy_ext[EXT_W-1:SPLIT];
	assign ldx    = {1'b0, dx_ext[SPLIT-1:0]};
	assign ldy    = {1'b0, dy_ext[SPLIT-1:0]};

	// stage 1: eight partial products
	logic signed [PROD_W-1:0] hdxc_s1, ldxc_s1, hdys_s1, ldys_s1;
	logic signed [PROD_W-1:0] hdyc_s1, ldyc_s1, hdxs_s1, ldxs_s1;
	logic signed [COORD_WIDTH-1:0] cx_s1, cy_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			hdxc_s1 <= hdx * cos_in;
			ldxc_s1 <= ldx * cos_in;
			hdys_s1 <= hdy * sin_in;
			ldys_s1 <= ldy * sin_in;
			hdyc_s1 <= hdy * cos_in;
			ldyc_s1 <= ldy * cos_in;
			hdxs_s1 <= hdx * sin_in;
			ldxs_s1 <= ldx * sin_in;
			cx_s1   <= cx;
			cy_s1   <= cy;
		end
	end

	// stage 2: x = dx*c - dy*s, y = dy*c + dx*s, per half
	logic signed [PSUM_W-1:0] hx_s2, lx_s2, hy_s2, ly_s2;
	logic signed [COORD_WIDTH-1:0] cx_s2, cy_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			hx_s2 <= PSUM_W'(hdxc_s1) - PSUM_W'(hdys_s1);
			lx_s2 <= PSUM_W'(ldxc_s1) - PSUM_W'(ldys_s1);
			hy_s2 <= PSUM_W'(hdyc_s1) + PSUM_W'(hdxs_s1);
			ly_s2 <= PSUM_W'(ldyc_s1) + PSUM_W'(ldxs_s1);
			cx_s2 <= cx_s1;
			cy_s2 <= cy_s1;
		end
	end

	// stage 3: recombine halves, round half up, drop the Q2.30 fraction
	logic signed [ACC_W-1:0] acc_x, acc_y;
	assign acc_x = (ACC_W'(hx_s2) <<< SPLIT) + ACC_W'(lx_s2) + rpc_pkg::ROUND_HALF;
	assign acc_y = (ACC_W'(hy_s2) <<< SPLIT) + ACC_W'(ly_s2) + rpc_pkg::ROUND_HALF;

	logic signed [ROT_W-1:0] rx_s3, ry_s3;
	logic signed [COORD_WIDTH-1:0] cx_s3, cy_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			rx_s3 <= acc_x[ACC_W-1:FRAC];
			ry_s3 <= acc_y[ACC_W-1:FRAC];
			cx_s3 <= cx_s2;
			cy_s3 <= cy_s2;
		end
	end

	// stage 4: add center back and clamp
	logic signed [SUM_W-1:0] sx, sy;
	logic signed [SUM_W-1:0] sx_sat, sy_sat;
	assign sx = SUM_W'(rx_s3) + SUM_W'(cx_s3);
	assign sy = SUM_W'(ry_s3) + SUM_W'(cy_s3);

	always_comb begin
		priority if (sx > SAT_HI) begin
			sx_sat = SAT_HI;
		end else if (sx < SAT_LO) begin
			sx_sat = SAT_LO;
		end else begin
			sx_sat = sx;
		end
		priority if (sy > SAT_HI) begin
			sy_sat = SAT_HI;
		end else if (sy < SAT_LO) begin
			sy_sat = SAT_LO;
		end else begin
			sy_sat = sy;
		end
	end

	logic signed [COORD_WIDTH-1:0] ox_s4, oy_s4;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			ox_s4 <= sx_sat[COORD_WIDTH-1:0];
			oy_s4 <= sy_sat[COORD_WIDTH-1:0];
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_q[3];
	assign out_x     = ox_s4;
	assign out_y     = oy_s4;

endmodule

/* hw/rtl/rotate_point_about_center_top.sv */
`timescale 1ns / 1ps

// Rotates a Q16.16 point about a Q16.16 center by a binary angle
// (2^ANGLE_WIDTH units per counter-clockwise turn) and returns the saturated
// rotated point. One transaction is accepted per clock while s_axis_tready
// is high. Results pass through a register for angle reduction and offset,
// the unrolled CORDIC that produces cos/sin in Q2.30, and the split multiply,
// rounding and center add with clamp. Each pipeline stage has its own valid
// bit and holds only when its successor is full and stalled, so bubbles
// close up behind a stalled output and s_axis_tready drops only when every
// stage holds an item. Because the CORDIC runs a fixed number of steps, an
// angle of zero gives a near-unit rather than an exact rotation.
module rotate_point_about_center_top #(
	parameter int COORD_WIDTH = 32,
	parameter int ANGLE_WIDTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// in_x, in_y, center_x, center_y, turn_angle (low to high), zero fill
	input  logic [((4*COORD_WIDTH+ANGLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// out_x, out_y (low to high), zero fill
	output logic [((2*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

	localparam int CW      = COORD_WIDTH;
	localparam int OUT_W   = ((2*COORD_WIDTH+7)/8)*8;
	localparam int PHASE_W = rpc_pkg::PHASE_W;
	localparam int SIDE_W  = 4*CW + 2;

	// unpack input transaction
	logic signed [CW-1:0]    px, py, cx, cy;
	logic [ANGLE_WIDTH-1:0]  angle;
	assign px    = s_axis_tdata[CW-1:0];
	assign py    = s_axis_tdata[2*CW-1:CW];
	assign cx    = s_axis_tdata[3*CW-1:2*CW];
	assign cy    = s_axis_tdata[4*CW-1:3*CW];
	assign angle = s_axis_tdata[4*CW+ANGLE_WIDTH-1:4*CW];

	// quadrant fold: second/third quadrant moves half a turn; the sign flip
	// of cos/sin is applied to the offset instead
	logic [PHASE_W-1:0]        phase;
	logic                      flip;
	logic signed [PHASE_W-1:0] z_red;
	logic signed [CW:0]        dx, dy;
	assign phase = {angle, {(PHASE_W-ANGLE_WIDTH){1'b0}}};
	assign flip  = phase[PHASE_W-1] ^ phase[PHASE_W-2];
	assign z_red = {phase[PHASE_W-1] ^ flip, phase[PHASE_W-2:0]};
	assign dx    = flip ? ((CW+1)'(cx) - (CW+1)'(px)) : ((CW+1)'(px) - (CW+1)'(cx));
	assign dy    = flip ? ((CW+1)'(cy) - (CW+1)'(py)) : ((CW+1)'(py) - (CW+1)'(cy));

	// stage 1 register
	logic                      v_s1;
	logic                      en_s1;
	logic                      cor_in_ready;
	logic signed [PHASE_W-1:0] z_s1;
	logic signed [CW:0]        dx_s1, dy_s1;
	logic signed [CW-1:0]      cx_s1, cy_s1;

	assign en_s1         = ~v_s1 | cor_in_ready;
	assign s_axis_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			z_s1  <= z_red;
			dx_s1 <= dx;
			dy_s1 <= dy;
			cx_s1 <= cx;
			cy_s1 <= cy;
		end
	end

	// CORDIC with offsets and center as side data
	logic                            cor_valid, rot_ready;
	logic signed [rpc_pkg::CS_W-1:0] cos_v, sin_v;
	logic [SIDE_W-1:0]               side_out;

	rpc_cordic #(
		.SIDE_W(SIDE_W)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_ready  (cor_in_ready),
		.in_z      (z_s1),
		.in_side   ({cy_s1, cx_s1, dy_s1, dx_s1}),
		.out_valid (cor_valid),
		.out_ready (rot_ready),
		.out_cos   (cos_v),
		.out_sin   (sin_v),
		.out_side  (side_out)
	);

	logic signed [CW:0]   dx_c, dy_c;
	logic signed [CW-1:0] cx_c, cy_c;
	assign dx_c = side_out[CW:0];
	assign dy_c = side_out[2*CW+1:CW+1];
	assign cx_c = side_out[3*CW+1:2*CW+2];
	assign cy_c = side_out[4*CW+1:3*CW+2];

	// rotate, round, re-center, saturate
	logic signed [CW-1:0] ox, oy;

	rpc_rotate #(
		.COORD_WIDTH(CW)
	) u_rotate (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cor_valid),
		.in_ready  (rot_ready),
		.cos_in    (cos_v),
		.sin_in    (sin_v),
		.dx        (dx_c),
		.dy        (dy_c),
		.cx        (cx_c),
		.cy        (cy_c),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_x     (ox),
		.out_y     (oy)
	);

	assign m_axis_tdata = OUT_W'({oy, ox});

endmodule
